// ----- hw/rtl/lbs_pkg.sv -----
`default_nettype none
package lbs_pkg;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned BITS_W  = 4;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [BITS_W-1:0] BITS_PER_BYTE = 4'd8;

  // action codes on the input word
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEND  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LATCH = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH     = 3'd4;

  localparam logic [TICK_W-1:0] RST_ONE_HIGH  = 16'd21;
  localparam logic [TICK_W-1:0] RST_ONE_LOW   = 16'd14;
  localparam logic [TICK_W-1:0] RST_ZERO_HIGH = 16'd9;
  localparam logic [TICK_W-1:0] RST_ZERO_LOW  = 16'd21;
  localparam logic [TICK_W-1:0] RST_LATCH     = 16'd142;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_SEND,
    CMD_LATCH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  function automatic logic [TICK_W-1:0] min_one(logic [TICK_W-1:0] n);
    return (n == '0) ? TICK_W'(1) : n;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/lbs_if.sv -----
`default_nettype none
interface lbs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface lbs_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic rejected;

  modport source (output valid, output line_level, output busy_res, output rejected,
                  input ready);
  modport sink (input valid, input line_level, input busy_res, input rejected,
                output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lbs_front.sv -----
`default_nettype none
module lbs_front
  import lbs_pkg::*;
(
  lbs_in_if.sink   in_bus,
  output logic     push,
  output cmd_t     push_cmd,
  input  logic     push_ready
);

  always_comb begin
    push_cmd.data = in_bus.data_byte;
    case (in_bus.action)
      ACT_SEND:  push_cmd.kind = CMD_SEND;
      ACT_LATCH: push_cmd.kind = CMD_LATCH;
      default:   push_cmd.kind = CMD_TICK; // unused code is a plain tick
    endcase
  end

  assign in_bus.ready = push_ready;
  assign push         = in_bus.valid & push_ready;

endmodule
`default_nettype wire

// ----- hw/rtl/lbs_queue.sv -----
`default_nettype none
module lbs_queue
  import lbs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic push_ready,
  input  logic pop,
  output cmd_t head_cmd,
  output logic head_valid
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/lbs_back.sv -----
`default_nettype none
module lbs_back
  import lbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [TICK_W-1:0]    cfg_wdata,
  input  logic                 head_valid,
  input  cmd_t                 head_cmd,
  output logic                 pop,
  lbs_out_if.source            out_bus
);

  logic [TICK_W-1:0] one_high_r, one_low_r, zero_high_r, zero_low_r, latch_r;

  logic [BYTE_W-1:0] shift_r, shift_nxt;
  logic [BITS_W-1:0] bits_r, bits_nxt;
  logic              high_r, high_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;
  logic              active_r, active_nxt;
  logic              latch_on_r, latch_on_nxt;

  logic out_valid_r, out_valid_nxt;
  logic level_r, busy_r, rej_r;
  logic level_nxt, busy_nxt, rej_nxt;

  logic [TICK_W-1:0] t_dec;
  logic [BYTE_W-1:0] sh_next;
  logic [BITS_W-1:0] bits_dec;

  assign pop = head_valid & (~out_valid_r | out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_high_r  <= RST_ONE_HIGH;
      one_low_r   <= RST_ONE_LOW;
      zero_high_r <= RST_ZERO_HIGH;
      zero_low_r  <= RST_ZERO_LOW;
      latch_r     <= RST_LATCH;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ONE_HIGH:  one_high_r  <= cfg_wdata;
        REG_ONE_LOW:   one_low_r   <= cfg_wdata;
        REG_ZERO_HIGH: zero_high_r <= cfg_wdata;
        REG_ZERO_LOW:  zero_low_r  <= cfg_wdata;
        REG_LATCH:     latch_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    shift_nxt    = shift_r;
    bits_nxt     = bits_r;
    high_nxt     = high_r;
    ticks_nxt    = ticks_r;
    active_nxt   = active_r;
    latch_on_nxt = latch_on_r;
    rej_nxt      = 1'b0;
    level_nxt    = 1'b0;
    busy_nxt     = 1'b0;
    t_dec        = '0;
    sh_next      = '0;
    bits_dec     = '0;

    // start takes effect on the same tick
    case (head_cmd.kind)
      CMD_SEND: begin
        if (active_r) begin
          rej_nxt = 1'b1;
        end else begin
          active_nxt   = 1'b1;
          latch_on_nxt = 1'b0;
          shift_nxt    = head_cmd.data;
          bits_nxt     = BITS_PER_BYTE;
          high_nxt     = 1'b1;
          ticks_nxt    = min_one(head_cmd.data[BYTE_W-1] ? one_high_r : zero_high_r);
        end
      end
      CMD_LATCH: begin
        if (active_r) begin
          rej_nxt = 1'b1;
        end else begin
          active_nxt   = 1'b1;
          latch_on_nxt = 1'b1;
          high_nxt     = 1'b0;
          ticks_nxt    = min_one(latch_r);
        end
      end
      default: ;
    endcase

    if (active_nxt) begin
      busy_nxt  = 1'b1;
      level_nxt = ~latch_on_nxt & high_nxt;
      t_dec     = ticks_nxt - 1'b1;
      ticks_nxt = t_dec;
      if (t_dec == '0) begin
        if (latch_on_nxt) begin
          latch_on_nxt = 1'b0;
          active_nxt   = 1'b0;
        end else if (high_nxt) begin
          high_nxt  = 1'b0;
          ticks_nxt = min_one(shift_nxt[BYTE_W-1] ? one_low_r : zero_low_r);
        end else begin
          sh_next   = {shift_nxt[BYTE_W-2:0], 1'b0};
          bits_dec  = bits_nxt - 1'b1;
          shift_nxt = sh_next;
          bits_nxt  = bits_dec;
          if (bits_dec == '0) begin
            active_nxt = 1'b0;
          end else begin
            high_nxt  = 1'b1;
            ticks_nxt = min_one(sh_next[BYTE_W-1] ? one_high_r : zero_high_r);
          end
        end
      end
    end

    out_valid_nxt = pop | (out_valid_r & ~out_bus.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= '0;
      bits_r      <= '0;
      high_r      <= 1'b0;
      ticks_r     <= '0;
      active_r    <= 1'b0;
      latch_on_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        shift_r    <= shift_nxt;
        bits_r     <= bits_nxt;
        high_r     <= high_nxt;
        ticks_r    <= ticks_nxt;
        active_r   <= active_nxt;
        latch_on_r <= latch_on_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      level_r <= level_nxt;
      busy_r  <= busy_nxt;
      rej_r   <= rej_nxt;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.line_level = level_r;
  assign out_bus.busy_res   = busy_r;
  assign out_bus.rejected   = rej_r;

  a_ticks_live: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> ticks_r != '0)
    else $error("active phase with no ticks left");

  a_idle_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> bits_r == '0)
    else $error("idle with bits still pending");

  a_latch_low: assert property (@(posedge clk) disable iff (!rst_n)
    latch_on_r |-> (active_r && !high_r))
    else $error("latch gap state inconsistent");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |-> !pop)
    else $error("result register overwritten while stalled");

  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && rej_nxt) |-> active_r)
    else $error("start rejected while idle");

endmodule
`default_nettype wire

// ----- hw/rtl/led_strip_bit_serializer.sv -----
// channel  | dir | word
// in_bus   | in  | action[1:0], data_byte[7:0]
// out_bus  | out | line_level, busy_res, rejected
// cfg_*    | in  | cfg_we, cfg_idx[2:0], cfg_wdata[15:0]
//
// One word in and one word out per cycle when neither side stalls.
// Each word passes through the two-entry command queue and then the
// result register of the serializer.
// Synchronous active-low reset idles the line and restores default timings.
// A stalled output holds its word; the queue then fills and in_bus.ready
// drops once it holds two words.
`default_nettype none
module led_strip_bit_serializer
  import lbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [TICK_W-1:0]    cfg_wdata,
  lbs_in_if.sink               in_bus,
  lbs_out_if.source            out_bus
);

  logic push, push_ready, pop, head_valid;
  cmd_t push_cmd, head_cmd;

  lbs_front u_front (
    .in_bus     (in_bus),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  lbs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .head_cmd   (head_cmd),
    .head_valid (head_valid)
  );

  lbs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_bus    (out_bus)
  );

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
module tb;
  import lbs_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  // indexes past the last register, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_NONE_LO  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_MID = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_HI  = 3'd7;
  localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;
  localparam logic [TICK_W-1:0] LONG_TICKS = 16'd12;
  localparam int QUIET_LIMIT = 200;
  localparam int DRAIN_PAD = 8;
  localparam int RAND_PHASES = 4;
  localparam int PHASE_WORDS = 12;

  typedef struct packed {
    logic level;
    logic busy;
    logic rejected;
  } line_word_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [TICK_W-1:0]    cfg_wdata;

  lbs_in_if  in_bus ();
  lbs_out_if out_bus ();

  led_strip_bit_serializer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_bus   (in_bus),
    .out_bus  (out_bus)
  );

  // line predictor state
  logic [TICK_W-1:0] tick_cfg [0:4];
  logic [BYTE_W-1:0] pattern;
  logic [BITS_W-1:0] bits_to_go;
  logic              in_high;
  logic [TICK_W-1:0] ticks_to_go;
  logic              sending;
  logic              gapping;

  line_word_t line_q [$];

  int gap_max = 4;
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int starts_taken = 0;
  int starts_dropped = 0;
  int quiet = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [TICK_W-1:0] at_least1(logic [TICK_W-1:0] n);
    if (n == 0) return 16'd1;
    return n;
  endfunction

  function automatic void load_phase(logic high);
    in_high = high;
    if (high)
      ticks_to_go = at_least1(pattern[7] ? tick_cfg[REG_ONE_HIGH] : tick_cfg[REG_ZERO_HIGH]);
    else
      ticks_to_go = at_least1(pattern[7] ? tick_cfg[REG_ONE_LOW] : tick_cfg[REG_ZERO_LOW]);
  endfunction

  function automatic void phase_done();
    if (gapping) begin
      gapping = 1'b0;
      sending = 1'b0;
      ticks_to_go = '0;
    end else if (in_high) begin
      load_phase(1'b0);
    end else begin
      pattern = pattern << 1;
      bits_to_go = bits_to_go - 1'b1;
      if (bits_to_go == 0) begin
        sending = 1'b0;
        ticks_to_go = '0;
      end else begin
        load_phase(1'b1);
      end
    end
  endfunction

  function automatic line_word_t step_line(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] data);
    line_word_t w;
    w = '0;
    if (act == ACT_SEND || act == ACT_LATCH) begin
      if (sending) begin
        w.rejected = 1'b1;
        starts_dropped++;
      end else if (act == ACT_SEND) begin
        sending = 1'b1;
        gapping = 1'b0;
        pattern = data;
        bits_to_go = BITS_PER_BYTE;
        load_phase(1'b1);
        starts_taken++;
      end else begin
        sending = 1'b1;
        gapping = 1'b1;
        in_high = 1'b0;
        ticks_to_go = at_least1(tick_cfg[REG_LATCH]);
        starts_taken++;
      end
    end
    if (sending) begin
      w.busy = 1'b1;
      w.level = !gapping && in_high;
      ticks_to_go = ticks_to_go - 1'b1;
      if (ticks_to_go == 0) phase_done();
    end
    return w;
  endfunction

  task automatic reset_line_model();
    tick_cfg[REG_ONE_HIGH]  = RST_ONE_HIGH;
    tick_cfg[REG_ONE_LOW]   = RST_ONE_LOW;
    tick_cfg[REG_ZERO_HIGH] = RST_ZERO_HIGH;
    tick_cfg[REG_ZERO_LOW]  = RST_ZERO_LOW;
    tick_cfg[REG_LATCH]     = RST_LATCH;
    pattern = '0;
    bits_to_go = '0;
    in_high = 1'b0;
    ticks_to_go = '0;
    sending = 1'b0;
    gapping = 1'b0;
  endtask

  task automatic report(string what, int expv, int gotv);
    $display("ERROR word %0d: %s expected %0d got %0d", words_checked, what, expv, gotv);
    errors++;
  endtask

  task automatic send_word(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] data);
    int gap;
    gap = $urandom_range(0, gap_max);
    repeat (gap) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid     <= 1'b1;
    in_bus.action    <= act;
    in_bus.data_byte <= data;
    do @(posedge clk); while (!in_bus.ready);
    line_q.push_back(step_line(act, data));
    words_sent++;
  endtask

  task automatic tick();
    send_word(ACT_TICK, BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic run_to_idle();
    while (sending) tick();
  endtask

  // drop valid and let every predicted word come out, plus the pipeline tail
  task automatic settle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (line_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (idx <= REG_LATCH) tick_cfg[idx] = val;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timing(logic [TICK_W-1:0] oh, logic [TICK_W-1:0] ol,
                            logic [TICK_W-1:0] zh, logic [TICK_W-1:0] zl,
                            logic [TICK_W-1:0] lt);
    settle();
    write_reg(REG_ONE_HIGH, oh);
    write_reg(REG_ONE_LOW, ol);
    write_reg(REG_ZERO_HIGH, zh);
    write_reg(REG_ZERO_LOW, zl);
    write_reg(REG_LATCH, lt);
    end_writes();
  endtask

  function automatic logic [TICK_W-1:0] pick_ticks();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return TICK_W'($urandom_range(5, 12));
    return TICK_W'($urandom_range(1, 2));
  endfunction

  task automatic test_defaults();
    tick();
    send_word(ACT_SPARE, 8'h00);
    send_word(ACT_TICK, 8'hFF);
    send_word(ACT_SEND, 8'hA5);
    repeat (5) tick();
    send_word(ACT_SEND, 8'h3C);
    send_word(ACT_LATCH, 8'hC3);
    send_word(ACT_SPARE, 8'hFF);
    run_to_idle();
    send_word(ACT_LATCH, 8'h00);
    send_word(ACT_SEND, 8'h55);
    run_to_idle();
    tick();
  endtask

  task automatic test_edges();
    logic [BYTE_W-1:0] bytes [2];
    bytes = '{8'hFF, 8'h80};
    set_timing(16'd1, 16'd2, 16'd3, 16'd4, 16'd1);
    // writes past the register file must not land anywhere
    write_reg(REG_NONE_LO, TICK_MAX);
    write_reg(REG_NONE_MID, 16'h5A5A);
    write_reg(REG_NONE_HI, 16'h0000);
    end_writes();
    foreach (bytes[i]) begin
      send_word(ACT_SEND, bytes[i]);
      run_to_idle();
    end
    send_word(ACT_LATCH, 8'hFF);
    run_to_idle();
    // zero counts stretch to one tick each
    set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_word(ACT_SEND, 8'h6A);
    run_to_idle();
    send_word(ACT_LATCH, 8'h00);
    send_word(ACT_SEND, 8'h96);
    send_word(ACT_LATCH, 8'h00);
    run_to_idle();
    send_word(ACT_LATCH, 8'h00);
    send_word(ACT_LATCH, 8'h00);
    run_to_idle();
  endtask

  task automatic test_mid_transfer();
    set_timing(16'd2, 16'd2, 16'd2, 16'd2, 16'd3);
    send_word(ACT_SEND, 8'hC3);
    repeat (6) tick();
    set_timing(16'd4, 16'd1, 16'd1, 16'd4, 16'd6);
    run_to_idle();
    send_word(ACT_LATCH, 8'h00);
    repeat (2) tick();
    // latch length already loaded, new value only counts for the next gap
    set_timing(16'd4, 16'd1, 16'd1, 16'd4, 16'd2);
    run_to_idle();
    send_word(ACT_LATCH, 8'h00);
    run_to_idle();
  endtask

  task automatic test_long_phases();
    gap_max = 0;
    set_timing(LONG_TICKS, LONG_TICKS, 16'd1, 16'd1, 16'd1);
    send_word(ACT_SEND, 8'h80);
    run_to_idle();
    set_timing(16'd1, 16'd1, LONG_TICKS, LONG_TICKS, LONG_TICKS);
    send_word(ACT_SEND, 8'h7F);
    run_to_idle();
    send_word(ACT_LATCH, 8'h00);
    run_to_idle();
    gap_max = 4;
  endtask

  task automatic test_random();
    int r;
    for (int p = 0; p < RAND_PHASES; p++) begin
      gap_max = (p == 2) ? 0 : 4;
      set_timing(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_NONE_LO, REG_NONE_HI)),
                  TICK_W'($urandom_range(0, 65535)));
        end_writes();
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (!sending) begin
          r = $urandom_range(0, 9);
          if (r < 6) send_word(ACT_SEND, BYTE_W'($urandom_range(0, 255)));
          else if (r < 8) send_word(ACT_LATCH, BYTE_W'($urandom_range(0, 255)));
          else if (r == 8) tick();
          else send_word(ACT_SPARE, BYTE_W'($urandom_range(0, 255)));
        end else begin
          r = $urandom_range(0, 19);
          if (r == 0) send_word(ACT_SEND, BYTE_W'($urandom_range(0, 255)));
          else if (r == 1) send_word(ACT_LATCH, BYTE_W'($urandom_range(0, 255)));
          else if (r == 2) send_word(ACT_SPARE, BYTE_W'($urandom_range(0, 255)));
          else tick();
        end
      end
    end
    gap_max = 4;
    run_to_idle();
  endtask

  // result side: random stalls, each word checked against the oldest prediction
  initial begin : result_side
    int stall;
    line_word_t got;
    line_word_t want;
    out_bus.ready = 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      stall = $urandom_range(0, gap_max);
      repeat (stall) begin
        @(negedge clk);
        out_bus.ready <= 1'b0;
      end
      @(negedge clk);
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      got = '{out_bus.line_level, out_bus.busy_res, out_bus.rejected};
      if (line_q.size() == 0) begin
        report("unexpected word, level", -1, got.level);
      end else begin
        want = line_q.pop_front();
        if (got.level !== want.level) report("line_level", want.level, got.level);
        if (got.busy !== want.busy) report("busy_res", want.busy, got.busy);
        if (got.rejected !== want.rejected) report("rejected", want.rejected, got.rejected);
      end
      words_checked++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("ERROR: no word moved for %0d cycles, %0d still expected",
                 QUIET_LIMIT, line_q.size());
        $display("led_strip_bit_serializer: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.action = ACT_TICK;
    in_bus.data_byte = '0;
    reset_line_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_defaults();
    test_edges();
    test_mid_transfer();
    test_long_phases();
    test_random();
    settle();

    $display("%0d words in, %0d checked, %0d errors", words_sent, words_checked, errors);
    $display("starts taken %0d, dropped while busy %0d, over default, zero and rewritten timings",
             starts_taken, starts_dropped);
    if (errors == 0)
      $display("led_strip_bit_serializer: match");
    else
      $display("led_strip_bit_serializer: mismatch");
    $finish;
  end

endmodule
